// ----- hw/rtl/seven_segment_digit_reader_macros.svh -----
// ---------------------------------------------------------------------------
// seven_segment_digit_reader_macros.svh
// assertion macros used by the checker file of the digit reader
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_DIGIT_READER_MACROS_SVH
`define SEVEN_SEGMENT_DIGIT_READER_MACROS_SVH

// clocked assertion, switched off while reset is high
`define SSDR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also covers the reset cycles
`define SSDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ssdr_pkg.sv -----
// ---------------------------------------------------------------------------
// ssdr_pkg
// types, constants and the pattern classifier of the seven segment digit reader
// ---------------------------------------------------------------------------
package ssdr_pkg;

   localparam int SEG_BITS    = 7;
   localparam int DIGIT_BITS  = 4;
   localparam int DIGIT_COUNT = 10;

   localparam logic [7:0] LIT_VALUE = 8'd255;

   // segment flag bits, bit0 = a through bit6 = g
   localparam logic [SEG_BITS-1:0] SEG_A = 7'h01;
   localparam logic [SEG_BITS-1:0] SEG_B = 7'h02;
   localparam logic [SEG_BITS-1:0] SEG_C = 7'h04;
   localparam logic [SEG_BITS-1:0] SEG_D = 7'h08;
   localparam logic [SEG_BITS-1:0] SEG_E = 7'h10;
   localparam logic [SEG_BITS-1:0] SEG_F = 7'h20;
   localparam logic [SEG_BITS-1:0] SEG_G = 7'h40;

   localparam logic [DIGIT_BITS-1:0] DIGIT_ONE = 4'd1;

   // gfedcba patterns; the entry for one is never matched, one comes from the aspect test
   localparam logic [SEG_BITS-1:0] DIGIT_PATTERNS [DIGIT_COUNT] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   // register indexes of the configuration port
   typedef enum logic {
      CSR_REGION_HEIGHT = 1'b0,
      CSR_REGION_WIDTH  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DIGIT_BITS-1:0] digit;
      logic                  recognized;
      logic [SEG_BITS-1:0]   segments;
   } result_type;

   // tall narrow region is a one, otherwise match the fixed patterns
   function automatic result_type classify(logic [SEG_BITS-1:0] flags, logic narrow);
      result_type r;
      r.digit      = '0;
      r.recognized = 1'b0;
      r.segments   = flags;
      if (narrow) begin
         r.digit      = DIGIT_ONE;
         r.recognized = 1'b1;
      end else begin
         // walk downward so the lowest matching digit wins
         for (int k = DIGIT_COUNT - 1; k >= 0; k--) begin
            if (DIGIT_BITS'(k) != DIGIT_ONE && flags == DIGIT_PATTERNS[k]) begin
               r.digit      = DIGIT_BITS'(k);
               r.recognized = 1'b1;
            end
         end
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/seven_segment_digit_reader.sv -----
// ---------------------------------------------------------------------------
// seven_segment_digit_reader
// reads one seven segment digit from a binarized region streamed pixel by pixel
// ---------------------------------------------------------------------------
// usage:
//   write the region height (index 0) and width (index 1) on the csr port
//   while the block is idle; a value of zero counts as one.
//   stream the region's pixels in raster order on req_; 255 is a lit pixel.
//   after the last pixel of the region one transaction appears on rsp_ with
//   the digit, the recognized flag and the gathered segment flags.
// timing:
//   one pixel per cycle sustained while no region end waits on a stalled
//   output; a pixel is held in the input register, and the result of a region
//   is written to the output register as its last pixel is consumed.
//   the per-pixel update is a handful of compares between the input register
//   and the output register; the divide by three of the height runs on the
//   csr write, not per pixel.
// reset clears the counters, the flags and both valid bits, and sets the
//   region to one by one. while rsp_stall holds a waiting result, pixels that
//   do not end a region keep flowing; a region end waits for the output slot.
// ---------------------------------------------------------------------------
module seven_segment_digit_reader #(
   parameter int COORD_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   // pixel input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_pixel_value,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ssdr_pkg::DIGIT_BITS-1:0] rsp_digit,
   output logic                            rsp_recognized,
   output logic [ssdr_pkg::SEG_BITS-1:0]   rsp_segments,
   // configuration writes
   input  logic                            csr_wr_en,
   input  ssdr_pkg::csr_index_type         csr_index,
   input  logic [COORD_BITS-1:0]           csr_wdata
);
   import ssdr_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic                  in_lit_ff, in_lit_in;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_data_ff, out_data_in;

   logic [COORD_BITS-1:0] last_row_idx;
   logic [COORD_BITS-1:0] last_col_idx;
   logic [COORD_BITS-1:0] mid_col;
   logic [COORD_BITS-1:0] upper_row;
   logic [COORD_BITS-1:0] lower_row;
   logic                  narrow;
   logic                  region_end;
   result_type            result;
   logic                  out_free;
   logic                  step;
   logic                  req_fire;

   ssdr_cfg #(
      .COORD_BITS(COORD_BITS)
   ) u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .last_row_idx (last_row_idx),
      .last_col_idx (last_col_idx),
      .mid_col      (mid_col),
      .upper_row    (upper_row),
      .lower_row    (lower_row),
      .narrow       (narrow)
   );

   ssdr_scan #(
      .COORD_BITS(COORD_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .lit          (in_lit_ff),
      .last_row_idx (last_row_idx),
      .last_col_idx (last_col_idx),
      .mid_col      (mid_col),
      .upper_row    (upper_row),
      .lower_row    (lower_row),
      .narrow       (narrow),
      .region_end   (region_end),
      .result       (result)
   );

   // handshake: only a region end needs the output slot
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && (!region_end || out_free);
   assign req_stall = in_valid_ff && !step;
   assign req_fire  = req_valid && !req_stall;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_lit_in   = in_lit_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_lit_in   = (req_pixel_value == LIT_VALUE);
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (step && region_end) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_lit_ff   <= in_lit_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_digit      = out_data_ff.digit;
   assign rsp_recognized = out_data_ff.recognized;
   assign rsp_segments   = out_data_ff.segments;

endmodule

// ----- hw/rtl/ssdr_cfg.sv -----
// ---------------------------------------------------------------------------
// ssdr_cfg
// region size registers and the probe geometry derived from them at write time
// ---------------------------------------------------------------------------
module ssdr_cfg #(
   parameter int COORD_BITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  ssdr_pkg::csr_index_type     csr_index,
   input  logic [COORD_BITS-1:0]       csr_wdata,
   output logic [COORD_BITS-1:0]       last_row_idx,
   output logic [COORD_BITS-1:0]       last_col_idx,
   output logic [COORD_BITS-1:0]       mid_col,
   output logic [COORD_BITS-1:0]       upper_row,
   output logic [COORD_BITS-1:0]       lower_row,
   output logic                        narrow
);
   import ssdr_pkg::*;

   // floor(h/3) = (h * RECIP) >> (COORD_BITS+1) for every h below 2**COORD_BITS
   localparam logic [COORD_BITS-1:0] RECIP = COORD_BITS'((2 ** (COORD_BITS + 1) + 2) / 3);

   logic [COORD_BITS-1:0]   height_ff, height_in;
   logic [COORD_BITS-1:0]   width_ff, width_in;
   logic [COORD_BITS-1:0]   last_row_ff, last_row_in;
   logic [COORD_BITS-1:0]   last_col_ff, last_col_in;
   logic [COORD_BITS-1:0]   mid_col_ff, mid_col_in;
   logic [COORD_BITS-1:0]   upper_row_ff, upper_row_in;
   logic [COORD_BITS-1:0]   lower_row_ff, lower_row_in;
   logic                    narrow_ff, narrow_in;

   logic [COORD_BITS-1:0]   wr_eff;
   logic [2*COORD_BITS-1:0] third_prod;
   logic [COORD_BITS-1:0]   third;
   logic [COORD_BITS+1:0]   width_x3;
   logic [COORD_BITS+1:0]   height_ext;

   // a size of zero counts as one
   assign wr_eff = (csr_wdata == '0) ? COORD_BITS'(1) : csr_wdata;

   // divide the new height by three
   assign third_prod = {{COORD_BITS{1'b0}}, wr_eff} * {{COORD_BITS{1'b0}}, RECIP};
   assign third      = {1'b0, third_prod[2*COORD_BITS-1:COORD_BITS+1]};

   // next register values
   always_comb begin
      height_in    = height_ff;
      width_in     = width_ff;
      last_row_in  = last_row_ff;
      last_col_in  = last_col_ff;
      mid_col_in   = mid_col_ff;
      upper_row_in = upper_row_ff;
      lower_row_in = lower_row_ff;
      width_x3     = {2'b00, width_ff} + {1'b0, width_ff, 1'b0};
      height_ext   = {2'b00, height_ff};
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REGION_HEIGHT: begin
               height_in    = wr_eff;
               last_row_in  = wr_eff - COORD_BITS'(1);
               upper_row_in = third;
               lower_row_in = {third[COORD_BITS-2:0], 1'b0};
               height_ext   = {2'b00, wr_eff};
            end
            CSR_REGION_WIDTH: begin
               width_in    = wr_eff;
               last_col_in = wr_eff - COORD_BITS'(1);
               mid_col_in  = wr_eff >> 1;
               width_x3    = {2'b00, wr_eff} + {1'b0, wr_eff, 1'b0};
            end
            default: ;
         endcase
      end
      narrow_in = width_x3 < height_ext;
   end

   // registers, reset to a one by one region
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff    <= COORD_BITS'(1);
         width_ff     <= COORD_BITS'(1);
         last_row_ff  <= '0;
         last_col_ff  <= '0;
         mid_col_ff   <= '0;
         upper_row_ff <= '0;
         lower_row_ff <= '0;
         narrow_ff    <= 1'b0;
      end else begin
         height_ff    <= height_in;
         width_ff     <= width_in;
         last_row_ff  <= last_row_in;
         last_col_ff  <= last_col_in;
         mid_col_ff   <= mid_col_in;
         upper_row_ff <= upper_row_in;
         lower_row_ff <= lower_row_in;
         narrow_ff    <= narrow_in;
      end
   end

   assign last_row_idx = last_row_ff;
   assign last_col_idx = last_col_ff;
   assign mid_col      = mid_col_ff;
   assign upper_row    = upper_row_ff;
   assign lower_row    = lower_row_ff;
   assign narrow       = narrow_ff;

endmodule

// ----- hw/rtl/ssdr_scan.sv -----
// ---------------------------------------------------------------------------
// ssdr_scan
// row and column tracking, probe line tests and segment flag accumulation
// ---------------------------------------------------------------------------
module ssdr_scan #(
   parameter int COORD_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       lit,
   input  logic [COORD_BITS-1:0]      last_row_idx,
   input  logic [COORD_BITS-1:0]      last_col_idx,
   input  logic [COORD_BITS-1:0]      mid_col,
   input  logic [COORD_BITS-1:0]      upper_row,
   input  logic [COORD_BITS-1:0]      lower_row,
   input  logic                       narrow,
   output logic                       region_end,
   output ssdr_pkg::result_type       result
);
   import ssdr_pkg::*;

   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [SEG_BITS-1:0]   flags_ff, flags_in;
   logic [SEG_BITS-1:0]   hits;
   logic [SEG_BITS-1:0]   flags_now;
   logic                  last_col;
   logic                  last_row;
   logic                  left_half;

   assign last_col   = col_ff >= last_col_idx;
   assign last_row   = row_ff >= last_row_idx;
   assign region_end = last_col && last_row;
   assign left_half  = col_ff < mid_col;

   // segments hit by the current pixel
   always_comb begin
      hits = '0;
      if (lit) begin
         if (col_ff == mid_col) begin
            priority if (row_ff < upper_row) hits = hits | SEG_A;
            else if (row_ff < lower_row)     hits = hits | SEG_G;
            else                             hits = hits | SEG_D;
         end
         if (row_ff == upper_row) hits = hits | (left_half ? SEG_F : SEG_B);
         if (row_ff == lower_row) hits = hits | (left_half ? SEG_E : SEG_C);
      end
   end

   assign flags_now = flags_ff | hits;
   assign result    = classify(flags_now, narrow);

   // counter and flag update for one pixel
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      flags_in = flags_ff;
      if (step) begin
         flags_in = region_end ? '0 : flags_now;
         if (!last_col) begin
            col_in = col_ff + COORD_BITS'(1);
         end else begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + COORD_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         flags_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         flags_ff <= flags_in;
      end
   end

endmodule

// ----- hw/rtl/ssdr_checker.sv -----
// ---------------------------------------------------------------------------
// ssdr_checker
// port level checks of the digit reader, bound to the top level
// ---------------------------------------------------------------------------
`include "seven_segment_digit_reader_macros.svh"

module ssdr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [ssdr_pkg::DIGIT_BITS-1:0] rsp_digit,
   input logic                            rsp_recognized,
   input logic [ssdr_pkg::SEG_BITS-1:0]   rsp_segments
);
   import ssdr_pkg::*;

   // a stalled result stays and keeps its payload
   `SSDR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit) && $stable(rsp_recognized) && $stable(rsp_segments), "stalled result changed")

   // no result in the cycle after reset
   `SSDR_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "result valid after reset")

   // digit range, and an unknown pattern reports zero
   `SSDR_ASSERT(a_digit_code, clock, reset, rsp_valid |-> (rsp_digit <= 4'd9) && (rsp_recognized || rsp_digit == '0), "bad digit code")

   // an eight needs every segment lit
   `SSDR_ASSERT(a_eight_full, clock, reset, rsp_valid && rsp_recognized && rsp_digit == 4'd8 |-> rsp_segments == DIGIT_PATTERNS[8], "eight without all segments")

endmodule

bind seven_segment_digit_reader ssdr_checker u_ssdr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_digit      (rsp_digit),
   .rsp_recognized (rsp_recognized),
   .rsp_segments   (rsp_segments)
);

// ----- tb/sv/ssdr_result_checker.sv -----
// ---------------------------------------------------------------------------
// ssdr_result_checker
// watches the pixel, result and csr ports of the digit reader, predicts each
// region's result from its own model of the probe lines and compares it
// field by field with the result transaction that comes out
// ---------------------------------------------------------------------------
module ssdr_result_checker
   import ssdr_pkg::*;
#(
   parameter int COORD_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [7:0]            req_pixel_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [DIGIT_BITS-1:0] rsp_digit,
   input  logic                  rsp_recognized,
   input  logic [SEG_BITS-1:0]   rsp_segments,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [COORD_BITS-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // segment shapes by digit, gfedcba; the slot for one is skipped
   localparam logic [SEG_BITS-1:0] SEGMENT_SHAPE [DIGIT_COUNT] = '{
      7'h3F, 7'h00, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   // predictor state: configuration copy, raster position, gathered flags
   logic [COORD_BITS-1:0] cfg_height;
   logic [COORD_BITS-1:0] cfg_width;
   logic [COORD_BITS-1:0] col_pos;
   logic [COORD_BITS-1:0] row_pos;
   logic [SEG_BITS-1:0]   seg_seen;
   result_type            digits_due [$];

   task automatic report_failure(input string msg);
      $display("%0t ns: %s", $realtime, msg);
      fail_count++;
   endtask

   // tall narrow regions read as one, otherwise the lowest matching shape wins
   function automatic result_type decide_digit(logic [SEG_BITS-1:0] flags, bit narrow);
      result_type r;
      r.digit      = '0;
      r.recognized = 1'b0;
      r.segments   = flags;
      if (narrow) begin
         r.digit      = DIGIT_ONE;
         r.recognized = 1'b1;
      end else begin
         for (int k = 0; k < DIGIT_COUNT; k++) begin
            if (k != int'(DIGIT_ONE) && !r.recognized && flags == SEGMENT_SHAPE[k]) begin
               r.digit      = DIGIT_BITS'(k);
               r.recognized = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // one accepted pixel: test the probe lines, step the raster position
   task automatic take_pixel(input logic [7:0] px);
      logic [COORD_BITS-1:0] h;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] x_mid;
      logic [COORD_BITS-1:0] y_upper;
      logic [COORD_BITS-1:0] y_lower;
      result_type            verdict;
      h       = (cfg_height == '0) ? COORD_BITS'(1) : cfg_height;
      w       = (cfg_width == '0) ? COORD_BITS'(1) : cfg_width;
      x_mid   = w >> 1;
      y_upper = COORD_BITS'(h / 3);
      y_lower = y_upper << 1;
      if (px == LIT_VALUE) begin
         if (col_pos == x_mid) begin
            if (row_pos < y_upper) seg_seen |= SEG_A;
            else if (row_pos < y_lower) seg_seen |= SEG_G;
            else seg_seen |= SEG_D;
         end
         if (row_pos == y_upper) seg_seen |= (col_pos < x_mid) ? SEG_F : SEG_B;
         if (row_pos == y_lower) seg_seen |= (col_pos < x_mid) ? SEG_E : SEG_C;
      end
      if (col_pos < w - 1'b1) begin
         col_pos = col_pos + 1'b1;
      end else begin
         col_pos = '0;
         if (row_pos < h - 1'b1) begin
            row_pos = row_pos + 1'b1;
         end else begin
            row_pos = '0;
            verdict = decide_digit(seg_seen, (3 * int'(w)) < int'(h));
            digits_due = {digits_due, verdict};
            seg_seen = '0;
         end
      end
   endtask

   // sample all ports at the rising edge
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         cfg_height = COORD_BITS'(1);
         cfg_width  = COORD_BITS'(1);
         col_pos    = '0;
         row_pos    = '0;
         seg_seen   = '0;
         fail_count = 0;
         digits_due.delete();
      end else begin
         // result transaction against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (digits_due.size() == 0) begin
               report_failure($sformatf("result with nothing expected: digit %0d segments %h",
                                        rsp_digit, rsp_segments));
            end else begin
               want = digits_due.pop_front();
               if (rsp_digit !== want.digit)
                  report_failure($sformatf("digit %0d, expected %0d", rsp_digit, want.digit));
               if (rsp_recognized !== want.recognized)
                  report_failure($sformatf("recognized %0b, expected %0b",
                                           rsp_recognized, want.recognized));
               if (rsp_segments !== want.segments)
                  report_failure($sformatf("segments %h, expected %h",
                                           rsp_segments, want.segments));
            end
         end
         if (req_valid && !req_stall) take_pixel(req_pixel_value);
         if (csr_wr_en) begin
            case (csr_index)
               CSR_REGION_HEIGHT: cfg_height = csr_wdata;
               CSR_REGION_WIDTH:  cfg_width  = csr_wdata;
               default: ;
            endcase
         end
      end
      pending_count = digits_due.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// testbench of the seven segment digit reader: streams digit regions of
// many sizes, painted to hit the probe lines with and without noise, under
// random gaps and stalls on both sides and one long result hold-off; the
// checker beside the block predicts and compares every result
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ssdr_pkg::*;

   localparam int COORD_BITS   = 10;
   localparam int STALL_LIMIT  = 2000;
   localparam int BURST_CYCLES = 300;
   localparam int REGION_GOAL  = 45;
   localparam int SETTLE       = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_pixel_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [DIGIT_BITS-1:0] rsp_digit;
   logic                  rsp_recognized;
   logic [SEG_BITS-1:0]   rsp_segments;
   logic                  csr_wr_en = 1'b0;
   csr_index_type         csr_index = CSR_REGION_HEIGHT;
   logic [COORD_BITS-1:0] csr_wdata = '0;

   int fail_count;
   int pending_count;
   int send_gap_pct = 30;
   int take_gap_pct = 50;
   int burst_left   = 0;
   int quiet_cycles = 0;

   seven_segment_digit_reader #(.COORD_BITS(COORD_BITS)) u_top (
      .clock, .reset,
      .req_valid, .req_stall, .req_pixel_value,
      .rsp_valid, .rsp_stall, .rsp_digit, .rsp_recognized, .rsp_segments,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   ssdr_result_checker #(.COORD_BITS(COORD_BITS)) u_check (
      .clock, .reset,
      .req_valid, .req_stall, .req_pixel_value,
      .rsp_valid, .rsp_stall, .rsp_digit, .rsp_recognized, .rsp_segments,
      .csr_wr_en, .csr_index, .csr_wdata,
      .fail_count, .pending_count
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // receiver: random stalls, or a long hold-off while burst_left runs down
   initial begin
      forever begin
         @(negedge clock);
         if (burst_left > 0) begin
            rsp_stall <= 1'b1;
            burst_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < take_gap_pct);
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // segments that a lit pixel at (r, c) would set, for painting regions
   function automatic logic [SEG_BITS-1:0] probe_hits(int r, int c, int h, int w);
      logic [SEG_BITS-1:0] hits;
      int x_mid;
      int y_upper;
      int y_lower;
      hits    = '0;
      x_mid   = w / 2;
      y_upper = h / 3;
      y_lower = 2 * y_upper;
      if (c == x_mid) hits |= (r < y_upper) ? SEG_A : (r < y_lower) ? SEG_G : SEG_D;
      if (r == y_upper) hits |= (c < x_mid) ? SEG_F : SEG_B;
      if (r == y_lower) hits |= (c < x_mid) ? SEG_E : SEG_C;
      return hits;
   endfunction

   // one pixel transaction, with random gaps before it
   task automatic send_pixel(input logic [7:0] px);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // drop valid and let every expected result come out, then settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_region(input int h, input int w);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_REGION_HEIGHT;
      csr_wdata <= COORD_BITS'(h);
      @(negedge clock);
      csr_index <= CSR_REGION_WIDTH;
      csr_wdata <= COORD_BITS'(w);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // light the pixels whose probe hits lie inside target, with optional noise
   task automatic paint_region(input int h, input int w, input logic [SEG_BITS-1:0] target,
                               input int noise_pct);
      int eh;
      int ew;
      logic [SEG_BITS-1:0] hits;
      bit lit;
      eh = (h == 0) ? 1 : h;
      ew = (w == 0) ? 1 : w;
      for (int r = 0; r < eh; r++) begin
         for (int c = 0; c < ew; c++) begin
            hits = probe_hits(r, c, eh, ew);
            lit  = (hits != '0) && ((hits & ~target) == '0);
            if ($urandom_range(99) < noise_pct) lit = !lit;
            send_pixel(lit ? LIT_VALUE : 8'($urandom_range(254, 0)));
         end
      end
   endtask

   // stimulus
   initial begin
      int cur_h;
      int cur_w;
      int burst_k;
      int sel;
      bit resize;
      logic [SEG_BITS-1:0] target;

      cur_h   = 1;
      cur_w   = 1;
      burst_k = 1 << 30;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: one by one region after reset, lit and unlit values
      send_pixel(LIT_VALUE);
      send_pixel(8'd254);
      send_pixel(8'd0);
      // zero sizes count as one
      wait_idle();
      set_region(0, 0);
      send_pixel(LIT_VALUE);
      // tall narrow region reads as one
      wait_idle();
      set_region(4, 1);
      repeat (4) send_pixel(LIT_VALUE);
      // short region, both probe rows on row zero
      wait_idle();
      set_region(2, 2);
      repeat (4) send_pixel(LIT_VALUE);
      // region shrunk mid-way still ends
      wait_idle();
      set_region(3, 3);
      repeat (4) send_pixel(LIT_VALUE);
      wait_idle();
      set_region(2, 2);
      send_pixel(LIT_VALUE);
      wait_idle();
      set_region(cur_h, cur_w);

      // random regions, three idling phases
      for (int k = 0; k < REGION_GOAL; k++) begin
         if (k == REGION_GOAL / 3) begin
            send_gap_pct = 50;
            take_gap_pct = 30;
         end
         if (k == 2 * REGION_GOAL / 3) begin
            send_gap_pct = 0;
            take_gap_pct = 0;
            burst_k      = k;
            burst_left   = BURST_CYCLES;
         end
         resize = (k == 0) || (k == 3) || (k == 4) || (k == 7) || (k == 8) ||
                  (k == 11) || (k == 14) ||
                  ($urandom_range(2) == 0 && !(k >= burst_k && k < burst_k + 8));
         if (resize) begin
            sel = $urandom_range(9);
            if (k == 3) begin
               cur_h = 1;
               cur_w = 255;
            end else if (k == 7) begin
               cur_h = 255;
               cur_w = 1;
            end else if (k == 11) begin
               cur_h = 0;
               cur_w = 5;
            end else if (k == 14) begin
               cur_h = 6;
               cur_w = 0;
            end else if (sel == 0) begin
               // around the tall narrow boundary
               cur_w = $urandom_range(3, 1);
               cur_h = 3 * cur_w + $urandom_range(2, 0);
            end else begin
               cur_h = $urandom_range(10, 1);
               cur_w = $urandom_range(6, 1);
            end
            wait_idle();
            set_region(cur_h, cur_w);
         end
         if ($urandom_range(3) == 0) target = SEG_BITS'($urandom_range(127, 0));
         else target = DIGIT_PATTERNS[$urandom_range(DIGIT_COUNT - 1, 0)];
         paint_region(cur_h, cur_w, target, ($urandom_range(3) == 0) ? 8 : 0);
      end

      // drain and verdict
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (2 * SETTLE) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- seven_segment_digit_reader.f -----
+incdir+hw/rtl
hw/rtl/ssdr_pkg.sv
hw/rtl/ssdr_cfg.sv
hw/rtl/ssdr_scan.sv
hw/rtl/seven_segment_digit_reader.sv
hw/rtl/ssdr_checker.sv
tb/sv/ssdr_result_checker.sv
tb/sv/tb_top.sv
